FILE: hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

	// Field widths
	localparam int unsigned CMD_W       = 3;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned TICKS_W     = 16;
	localparam int unsigned TIMEOUT_W   = 8;
	localparam int unsigned BIT_IDX_W   = 4;
	localparam int unsigned CFG_ADDR_W  = 1;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned S_TDATA_W   = 16;
	localparam int unsigned S_TUSER_W   = 3;
	localparam int unsigned M_TDATA_W   = 16;

	// Register reset values
	localparam logic [TICKS_W-1:0]   PHASE_TICKS_RST = 16'd5;
	localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;

	// Bits shifted per byte, and the read shift register preset
	localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;
	localparam logic [BYTE_W-1:0]    READ_PRESET   = 8'hFF;

	// Register indexes on the configuration port
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PHASE_TICKS = 1'b0,
		REG_ACK_TIMEOUT = 1'b1
	} reg_idx_t;

	// Command codes carried in s_tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// One result item, scl_level in the lowest bit
	typedef struct packed {
		logic              no_ack;
		logic [BYTE_W-1:0] read_byte;
		logic              done_res;
		logic              busy_res;
		logic              sda_drive;
		logic              sda_level;
		logic              scl_level;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_master_byte_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// I2C master byte sequencer.
// Each transaction on the s_ channel is one bus tick: an optional command in
// s_tuser (none, start, stop, write byte, read byte) plus the byte to write,
// the ACK/NACK choice for a read and the sampled SDA level in s_tdata. Every
// input transaction yields exactly one m_ transaction with the SCL/SDA pin
// levels, the SDA drive enable, busy and done flags, the last read byte and
// the no-acknowledge status of the last write.
// Commands are taken only while the sequencer is idle; each pin phase is held
// for phase_ticks ticks (0 acts as 1), and the acknowledge poll after a write
// gives up after ack_timeout further high samples.
// A tick passes from the input register through the phase step into the result
// register on m_tdata. Throughput: one transaction per cycle while the receiver
// keeps up; a stall fills the skid register and then holds the input.
// Reset: bus idle (SCL and SDA high, SDA driven), registers at 5 and 250.
// When the receiver stalls, one result waits in the output register and one
// in a skid register; s_tready drops once both are full and a third tick
// waits in the input register. The configuration port must be written only
// while no tick is in flight; the block itself does not enforce this.

module i2c_master_byte_sequencer (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Configuration write port
	input  wire                                   cfg_we,
	input  wire [i2cms_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire [i2cms_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Tick input
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// [7:0] write_byte, [8] send_ack, [9] sda_in, [15:10] zero
	input  wire [i2cms_pkg::S_TDATA_W-1:0]        s_tdata,
	// [2:0] command
	input  wire [i2cms_pkg::S_TUSER_W-1:0]        s_tuser,
	// Tick result
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [12:5] read_byte, [13] no_ack, [15:14] zero
	output logic [i2cms_pkg::M_TDATA_W-1:0]       m_tdata
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST0  = 5'd1,
		PH_ST1  = 5'd2,
		PH_ST2  = 5'd3,
		PH_ST3  = 5'd4,
		PH_SP0  = 5'd5,
		PH_SP1  = 5'd6,
		PH_SP2  = 5'd7,
		PH_WL   = 5'd8,
		PH_WH   = 5'd9,
		PH_A0   = 5'd10,
		PH_A1   = 5'd11,
		PH_A2   = 5'd12,
		PH_A3   = 5'd13,
		PH_POLL = 5'd14,
		PH_RL0  = 5'd15,
		PH_RH   = 5'd16,
		PH_RL   = 5'd17,
		PH_K0   = 5'd18,
		PH_K1   = 5'd19,
		PH_K2   = 5'd20,
		PH_K3   = 5'd21
	} phase_t;

	// Configuration registers
	logic [i2cms_pkg::TICKS_W-1:0]   phase_ticks_q;
	logic [i2cms_pkg::TIMEOUT_W-1:0] ack_timeout_q;

	// Input stage
	logic                             valid_s1;
	logic [i2cms_pkg::CMD_W-1:0]      cmd_s1;
	logic [i2cms_pkg::BYTE_W-1:0]     wbyte_s1;
	logic                             sack_s1;
	logic                             sda_s1;

	// Sequencer state
	phase_t                           phase_q;
	logic [i2cms_pkg::TICKS_W-1:0]    hold_q;
	logic [i2cms_pkg::BIT_IDX_W-1:0]  bit_idx_q;
	logic [i2cms_pkg::BYTE_W-1:0]     shift_q;
	logic [i2cms_pkg::TIMEOUT_W-1:0]  wait_q;
	logic                             ack_choice_q;
	logic                             scl_q;
	logic                             sda_q;
	logic                             sda_dir_q;
	logic                             nack_q;
	logic [i2cms_pkg::BYTE_W-1:0]     read_q;

	// Next-state values
	phase_t                           phase_n;
	logic [i2cms_pkg::TICKS_W-1:0]    hold_n;
	logic [i2cms_pkg::BIT_IDX_W-1:0]  bit_idx_n;
	logic [i2cms_pkg::BYTE_W-1:0]     shift_n;
	logic [i2cms_pkg::TIMEOUT_W-1:0]  wait_n;
	logic                             ack_choice_n;
	logic                             scl_n;
	logic                             sda_n;
	logic                             sda_dir_n;
	logic                             nack_n;
	logic [i2cms_pkg::BYTE_W-1:0]     read_n;
	logic                             done_c;
	logic                             ent_c;
	phase_t                           ent_ph_c;
	logic [i2cms_pkg::TICKS_W-1:0]    hold_load;
	i2cms_pkg::res_t                  res_c;

	// Output and skid registers
	logic                             out_valid_q;
	i2cms_pkg::res_t                  out_q;
	logic                             skid_valid_q;
	i2cms_pkg::res_t                  skid_q;

	logic                             s_accept;
	logic                             step;

	assign step     = valid_s1 && !skid_valid_q;
	assign s_tready = !valid_s1 || !skid_valid_q;
	assign s_accept = s_tvalid && s_tready;

	assign hold_load = (phase_ticks_q == '0) ? '0 : phase_ticks_q - 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cms_pkg::PHASE_TICKS_RST;
			ack_timeout_q <= i2cms_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				i2cms_pkg::REG_PHASE_TICKS: phase_ticks_q <= cfg_data;
				i2cms_pkg::REG_ACK_TIMEOUT:
					ack_timeout_q <= cfg_data[i2cms_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Track the input stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the input payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1   <= s_tuser[i2cms_pkg::CMD_W-1:0];
			wbyte_s1 <= s_tdata[7:0];
			sack_s1  <= s_tdata[8];
			sda_s1   <= s_tdata[9];
		end
	end

	// Step the phase sequencer by one tick
	always_comb begin
		phase_n      = phase_q;
		hold_n       = hold_q;
		bit_idx_n    = bit_idx_q;
		shift_n      = shift_q;
		wait_n       = wait_q;
		ack_choice_n = ack_choice_q;
		scl_n        = scl_q;
		sda_n        = sda_q;
		sda_dir_n    = sda_dir_q;
		nack_n       = nack_q;
		read_n       = read_q;
		done_c       = 1'b0;
		ent_c        = 1'b0;
		ent_ph_c     = PH_IDLE;

		case (phase_q)
			PH_IDLE: begin
				bit_idx_n = (cmd_s1 inside {i2cms_pkg::CMD_START, i2cms_pkg::CMD_STOP,
					i2cms_pkg::CMD_WRITE, i2cms_pkg::CMD_READ}) ? '0 : bit_idx_q;
				case (cmd_s1)
					i2cms_pkg::CMD_START: begin
						ent_c    = 1'b1;
						ent_ph_c = PH_ST0;
					end
					i2cms_pkg::CMD_STOP: begin
						ent_c    = 1'b1;
						ent_ph_c = PH_SP0;
					end
					i2cms_pkg::CMD_WRITE: begin
						shift_n  = wbyte_s1;
						ent_c    = 1'b1;
						ent_ph_c = PH_WL;
					end
					i2cms_pkg::CMD_READ: begin
						ack_choice_n = sack_s1;
						shift_n      = i2cms_pkg::READ_PRESET;
						ent_c        = 1'b1;
						ent_ph_c     = PH_RL0;
					end
					default: ;
				endcase
			end
			PH_POLL: begin
				if (!sda_s1) begin
					nack_n  = 1'b0;
					scl_n   = 1'b0;
					phase_n = PH_IDLE;
					hold_n  = '0;
					done_c  = 1'b1;
				end else if (wait_q >= ack_timeout_q) begin
					nack_n  = 1'b1;
					scl_n   = 1'b0;
					phase_n = PH_IDLE;
					hold_n  = '0;
					done_c  = 1'b1;
				end else begin
					wait_n = wait_q + 1'b1;
				end
			end
			default: begin
				if (phase_q > PH_K3) begin
					phase_n = PH_IDLE;
					hold_n  = '0;
					done_c  = 1'b1;
				end else if (hold_q != '0) begin
					hold_n = hold_q - 1'b1;
				end else begin
					// Leave the phase once its hold has run out
					ent_c = 1'b1;
					case (phase_q)
						PH_ST0: ent_ph_c = PH_ST1;
						PH_ST1: ent_ph_c = PH_ST2;
						PH_ST2: ent_ph_c = PH_ST3;
						PH_SP0: ent_ph_c = PH_SP1;
						PH_SP1: ent_ph_c = PH_SP2;
						PH_WL:  ent_ph_c = PH_WH;
						PH_WH: begin
							shift_n   = {shift_q[i2cms_pkg::BYTE_W-2:0], 1'b0};
							bit_idx_n = bit_idx_q + 1'b1;
							ent_ph_c  = (bit_idx_n >= i2cms_pkg::BITS_PER_BYTE) ?
								PH_A0 : PH_WL;
						end
						PH_A0:  ent_ph_c = PH_A1;
						PH_A1:  ent_ph_c = PH_A2;
						PH_A2:  ent_ph_c = PH_A3;
						PH_A3:  ent_ph_c = PH_POLL;
						PH_RL0: ent_ph_c = PH_RH;
						PH_RH: begin
							shift_n  = {shift_q[i2cms_pkg::BYTE_W-2:0], sda_s1};
							ent_ph_c = PH_RL;
						end
						PH_RL: begin
							bit_idx_n = bit_idx_q + 1'b1;
							ent_ph_c  = (bit_idx_n >= i2cms_pkg::BITS_PER_BYTE) ?
								PH_K0 : PH_RH;
						end
						PH_K0:  ent_ph_c = PH_K1;
						PH_K1:  ent_ph_c = PH_K2;
						PH_K2:  ent_ph_c = PH_K3;
						default: begin
							// Last phase of a command: stop, start and read end here
							if (phase_q == PH_K3) begin
								read_n = shift_q;
							end
							ent_c   = 1'b0;
							phase_n = PH_IDLE;
							hold_n  = '0;
							done_c  = 1'b1;
						end
					endcase
				end
			end
		endcase

		// Apply the pin settings of the phase being entered
		if (ent_c) begin
			phase_n = ent_ph_c;
			hold_n  = hold_load;
			case (ent_ph_c)
				PH_ST0: begin
					scl_n     = 1'b1;
					sda_dir_n = 1'b1;
				end
				PH_ST1: sda_n = 1'b1;
				PH_ST2: sda_n = 1'b0;
				PH_ST3: scl_n = 1'b0;
				PH_SP0: begin
					sda_dir_n = 1'b1;
					sda_n     = 1'b0;
				end
				PH_SP1: scl_n = 1'b1;
				PH_SP2: sda_n = 1'b1;
				PH_WL: begin
					scl_n     = 1'b0;
					sda_dir_n = 1'b1;
					sda_n     = shift_n[i2cms_pkg::BYTE_W-1];
				end
				PH_WH: scl_n = 1'b1;
				PH_A0: begin
					scl_n     = 1'b0;
					sda_dir_n = 1'b0;
				end
				PH_A1: scl_n = 1'b0;
				PH_A3: scl_n = 1'b1;
				PH_POLL: wait_n = '0;
				PH_RL0: begin
					scl_n     = 1'b0;
					sda_dir_n = 1'b0;
				end
				PH_RH: scl_n = 1'b1;
				PH_RL: scl_n = 1'b0;
				PH_K0: begin
					scl_n     = 1'b0;
					sda_dir_n = 1'b1;
				end
				PH_K1: sda_n = !ack_choice_q;
				PH_K2: scl_n = 1'b1;
				PH_K3: scl_n = 1'b0;
				default: ;
			endcase
		end

		res_c.scl_level = scl_n;
		res_c.sda_level = sda_n;
		res_c.sda_drive = sda_dir_n;
		res_c.busy_res  = (phase_n != PH_IDLE);
		res_c.done_res  = done_c;
		res_c.read_byte = read_n;
		res_c.no_ack    = nack_n;
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hold_q       <= '0;
			bit_idx_q    <= '0;
			shift_q      <= '0;
			wait_q       <= '0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			sda_dir_q    <= 1'b1;
			nack_q       <= 1'b0;
			read_q       <= '0;
		end else if (step) begin
			phase_q      <= phase_n;
			hold_q       <= hold_n;
			bit_idx_q    <= bit_idx_n;
			shift_q      <= shift_n;
			wait_q       <= wait_n;
			ack_choice_q <= ack_choice_n;
			scl_q        <= scl_n;
			sda_q        <= sda_n;
			sda_dir_q    <= sda_dir_n;
			nack_q       <= nack_n;
			read_q       <= read_n;
		end
	end

	// Track output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (step) begin
			if (!out_valid_q || m_tready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_valid_q && m_tready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load result payloads
	always_ff @(posedge clk) begin
		if (step) begin
			if (!out_valid_q || m_tready) begin
				out_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end else if (out_valid_q && m_tready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(i2cms_pkg::M_TDATA_W - i2cms_pkg::RES_W){1'b0}}, out_q};

	// The skid register only fills behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// A finishing tick always returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && done_c) |=> (phase_q == PH_IDLE))
		else $error("command finished but sequencer not idle");

	// SDA is released while polling for acknowledge
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_POLL) |-> !sda_dir_q)
		else $error("SDA driven during acknowledge poll");

	// The bit counter never passes one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q <= i2cms_pkg::BITS_PER_BYTE)
		else $error("bit counter beyond one byte");

endmodule

`default_nettype wire

FILE: dv/tb_i2c_master_byte_sequencer.sv
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer;
	import i2cms_pkg::*;

	localparam int unsigned HALF_NS      = 4;
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned MAX_GAP      = 14;
	localparam int unsigned PHASE_ACTIVE = 40;
	localparam int unsigned DRAIN_LIMIT  = 4000;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned ERR_PRINTS   = 100;
	localparam int unsigned CMD_CODES    = 1 << CMD_W;
	localparam longint unsigned LIMIT_NS = 64'd20_000_000;

	// Bus phases of the sequencer, in the order a command walks them
	typedef enum logic [4:0] {
		SQ_IDLE,
		SQ_STA0, SQ_STA1, SQ_STA2, SQ_STA3,
		SQ_STO0, SQ_STO1, SQ_STO2,
		SQ_WR_LOW, SQ_WR_HIGH,
		SQ_ACK0, SQ_ACK1, SQ_ACK2, SQ_ACK3, SQ_ACK_POLL,
		SQ_RD_SETUP, SQ_RD_HIGH, SQ_RD_LOW,
		SQ_MACK0, SQ_MACK1, SQ_MACK2, SQ_MACK3
	} seq_phase_e;

	// Tracks the pin sequencer tick by tick and checks each result against it
	class pin_scoreboard;
		logic [TICKS_W-1:0]   phase_ticks;
		logic [TIMEOUT_W-1:0] ack_timeout;
		seq_phase_e           phase;
		logic [TICKS_W-1:0]   hold;
		logic [BIT_IDX_W-1:0] bit_idx;
		logic [BYTE_W-1:0]    shreg;
		logic [TIMEOUT_W-1:0] wait_cnt;
		logic                 ack_choice;
		logic                 scl;
		logic                 sda;
		logic                 sda_dir;
		logic                 nack;
		logic [BYTE_W-1:0]    rd_result;
		res_t                 expected_pins[$];
		int unsigned          n_ticks;
		int unsigned          n_active;
		int unsigned          n_checked;
		int unsigned          n_errors;
		int unsigned          n_acks;
		int unsigned          n_nacks;
		int unsigned          n_cmd[CMD_CODES];

		function new();
			phase_ticks = PHASE_TICKS_RST;
			ack_timeout = ACK_TIMEOUT_RST;
			phase       = SQ_IDLE;
			hold        = '0;
			bit_idx     = '0;
			shreg       = '0;
			wait_cnt    = '0;
			ack_choice  = 1'b0;
			scl         = 1'b1;
			sda         = 1'b1;
			sda_dir     = 1'b1;
			nack        = 1'b0;
			rd_result   = '0;
			n_ticks     = 0;
			n_active    = 0;
			n_checked   = 0;
			n_errors    = 0;
			n_acks      = 0;
			n_nacks     = 0;
			foreach (n_cmd[i]) n_cmd[i] = 0;
		endfunction

		function bit is_idle();
			return phase == SQ_IDLE;
		endfunction

		function bit in_poll();
			return phase == SQ_ACK_POLL;
		endfunction

		function int unsigned pending();
			return expected_pins.size();
		endfunction

		// Load the phase hold and set the pins a phase drives on entry
		function void enter_phase(seq_phase_e p);
			phase = p;
			hold  = (phase_ticks == '0) ? '0 : phase_ticks - 1'b1;
			case (p)
			SQ_STA0: begin
				scl     = 1'b1;
				sda_dir = 1'b1;
			end
			SQ_STA1: sda = 1'b1;
			SQ_STA2: sda = 1'b0;
			SQ_STA3: scl = 1'b0;
			SQ_STO0: begin
				sda_dir = 1'b1;
				sda     = 1'b0;
			end
			SQ_STO1: scl = 1'b1;
			SQ_STO2: sda = 1'b1;
			SQ_WR_LOW: begin
				scl     = 1'b0;
				sda_dir = 1'b1;
				sda     = shreg[BYTE_W-1];
			end
			SQ_WR_HIGH: scl = 1'b1;
			SQ_ACK0: begin
				scl     = 1'b0;
				sda_dir = 1'b0;
			end
			SQ_ACK1: scl = 1'b0;
			SQ_ACK3: scl = 1'b1;
			SQ_ACK_POLL: wait_cnt = '0;
			SQ_RD_SETUP: begin
				scl     = 1'b0;
				sda_dir = 1'b0;
			end
			SQ_RD_HIGH: scl = 1'b1;
			SQ_RD_LOW: scl = 1'b0;
			SQ_MACK0: begin
				scl     = 1'b0;
				sda_dir = 1'b1;
			end
			SQ_MACK1: sda = ~ack_choice;
			SQ_MACK2: scl = 1'b1;
			SQ_MACK3: scl = 1'b0;
			default: ;
			endcase
		endfunction

		function void end_command();
			phase = SQ_IDLE;
			hold  = '0;
		endfunction

		// Move on once a phase has been held; report whether the command ended
		function bit leave_phase(logic sda_in);
			case (phase)
			SQ_STA0: enter_phase(SQ_STA1);
			SQ_STA1: enter_phase(SQ_STA2);
			SQ_STA2: enter_phase(SQ_STA3);
			SQ_STO0: enter_phase(SQ_STO1);
			SQ_STO1: enter_phase(SQ_STO2);
			SQ_WR_LOW: enter_phase(SQ_WR_HIGH);
			SQ_WR_HIGH: begin
				shreg   = shreg << 1;
				bit_idx = bit_idx + 1'b1;
				if (bit_idx >= BITS_PER_BYTE) enter_phase(SQ_ACK0);
				else enter_phase(SQ_WR_LOW);
			end
			SQ_ACK0: enter_phase(SQ_ACK1);
			SQ_ACK1: enter_phase(SQ_ACK2);
			SQ_ACK2: enter_phase(SQ_ACK3);
			SQ_ACK3: enter_phase(SQ_ACK_POLL);
			SQ_RD_SETUP: enter_phase(SQ_RD_HIGH);
			SQ_RD_HIGH: begin
				shreg = {shreg[BYTE_W-2:0], sda_in};
				enter_phase(SQ_RD_LOW);
			end
			SQ_RD_LOW: begin
				bit_idx = bit_idx + 1'b1;
				if (bit_idx >= BITS_PER_BYTE) enter_phase(SQ_MACK0);
				else enter_phase(SQ_RD_HIGH);
			end
			SQ_MACK0: enter_phase(SQ_MACK1);
			SQ_MACK1: enter_phase(SQ_MACK2);
			SQ_MACK2: enter_phase(SQ_MACK3);
			default: begin
				// last phase of start, stop or read
				if (phase == SQ_MACK3) rd_result = shreg;
				end_command();
				return 1'b1;
			end
			endcase
			return 1'b0;
		endfunction

		// Advance one bus tick for an accepted transaction and queue its pin state
		function void take_tick(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wbyte,
				logic sack, logic sda_in);
			res_t want;
			bit   done;
			bit   is_cmd;
			done   = 1'b0;
			is_cmd = (cmd >= CMD_START) && (cmd <= CMD_READ);
			n_ticks++;
			if (phase != SQ_IDLE || is_cmd) n_active++;
			if (phase == SQ_IDLE) begin
				if (is_cmd) n_cmd[cmd]++;
				case (cmd)
				CMD_START: enter_phase(SQ_STA0);
				CMD_STOP: enter_phase(SQ_STO0);
				CMD_WRITE: begin
					bit_idx = '0;
					shreg   = wbyte;
					enter_phase(SQ_WR_LOW);
				end
				CMD_READ: begin
					bit_idx    = '0;
					ack_choice = sack;
					shreg      = READ_PRESET;
					enter_phase(SQ_RD_SETUP);
				end
				default: ;
				endcase
			end else if (phase == SQ_ACK_POLL) begin
				// slave pulls SDA low, or the timeout runs out on a high sample
				if (!sda_in || wait_cnt >= ack_timeout) begin
					nack = sda_in;
					scl  = 1'b0;
					if (sda_in) n_nacks++;
					else n_acks++;
					end_command();
					done = 1'b1;
				end else begin
					wait_cnt = wait_cnt + 1'b1;
				end
			end else if (hold != '0) begin
				hold = hold - 1'b1;
			end else begin
				done = leave_phase(sda_in);
			end
			want.scl_level = scl;
			want.sda_level = sda;
			want.sda_drive = sda_dir;
			want.busy_res  = (phase != SQ_IDLE);
			want.done_res  = done;
			want.read_byte = rd_result;
			want.no_ack    = nack;
			expected_pins.push_back(want);
		endfunction

		function void compare_field(string name, logic [BYTE_W-1:0] want,
				logic [BYTE_W-1:0] got);
			if (got !== want) begin
				if (n_errors < ERR_PRINTS)
					$error("%s: expected %0h, got %0h (result %0d)", name, want, got, n_checked);
				n_errors++;
			end
		endfunction

		// Compare one result transaction with the oldest queued pin state
		function void check_pins(logic [M_TDATA_W-1:0] data);
			res_t got;
			res_t want;
			got = res_t'(data[RES_W-1:0]);
			if (expected_pins.size() == 0) begin
				$error("result %h arrived with no tick outstanding", data);
				n_errors++;
				return;
			end
			want = expected_pins.pop_front();
			compare_field("scl_level", BYTE_W'(want.scl_level), BYTE_W'(got.scl_level));
			compare_field("sda_level", BYTE_W'(want.sda_level), BYTE_W'(got.sda_level));
			compare_field("sda_drive", BYTE_W'(want.sda_drive), BYTE_W'(got.sda_drive));
			compare_field("busy_res", BYTE_W'(want.busy_res), BYTE_W'(got.busy_res));
			compare_field("done_res", BYTE_W'(want.done_res), BYTE_W'(got.done_res));
			compare_field("read_byte", want.read_byte, got.read_byte);
			compare_field("no_ack", BYTE_W'(want.no_ack), BYTE_W'(got.no_ack));
			n_checked++;
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic [S_TUSER_W-1:0]  s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;

	pin_scoreboard sb;
	bit            tx_idle = 1'b1;
	bit            rx_idle = 1'b1;

	i2c_master_byte_sequencer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#(HALF_NS) clk = 1'b1;
		#(HALF_NS) clk = 1'b0;
	end

	// Present one tick after an optional gap and hold it until accepted
	task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wbyte,
			input logic sack, input logic sda_in);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= S_TDATA_W'({sda_in, sack, wbyte});
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.take_tick(cmd, wbyte, sack, sda_in);
	endtask

	// Issue a command and keep ticking until the sequencer is idle again;
	// the slave acknowledges on poll sample ack_after, never if negative
	task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wbyte,
			input logic sack, input int ack_after);
		int          polls;
		logic [CMD_W-1:0] stray;
		logic        sda_in;
		polls = 0;
		send_tick(cmd, wbyte, sack, 1'($urandom));
		while (!sb.is_idle()) begin
			// commands in the middle of a sequence must be ignored
			stray = ($urandom_range(0, 99) < 15) ? CMD_W'($urandom) : CMD_NONE;
			if (sb.in_poll()) begin
				sda_in = (ack_after >= 0 && polls >= ack_after) ? 1'b0 : 1'b1;
				polls++;
			end else begin
				sda_in = 1'($urandom);
			end
			send_tick(stray, BYTE_W'($urandom), 1'($urandom), sda_in);
		end
	endtask

	// Hold off the sender until every queued result has come back
	task automatic settle();
		while (!sb.is_idle()) send_tick(CMD_NONE, '0, 1'b0, 1'($urandom));
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_regs(input logic [TICKS_W-1:0] ticks,
			input logic [TIMEOUT_W-1:0] timeout);
		cfg_we   <= 1'b1;
		cfg_addr <= REG_PHASE_TICKS;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_addr <= REG_ACK_TIMEOUT;
		cfg_data <= CFG_DATA_W'(timeout);
		@(posedge clk);
		cfg_we         <= 1'b0;
		sb.phase_ticks = ticks;
		sb.ack_timeout = timeout;
	endtask

	// Early acks most often, plus acks right at the timeout, one past it, and none
	function automatic int pick_ack_after();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4) return $urandom_range(0, 2);
		if (roll < 6) return int'(sb.ack_timeout);
		if (roll < 8) return int'(sb.ack_timeout) + 1;
		return -1;
	endfunction

	// Start, address byte, a few data bytes either way, stop
	task automatic run_transfer();
		int unsigned n;
		n = $urandom_range(1, 3);
		run_command(CMD_START, BYTE_W'($urandom), 1'($urandom), 0);
		run_command(CMD_WRITE, BYTE_W'($urandom), 1'($urandom), pick_ack_after());
		repeat (n) begin
			if ($urandom_range(0, 1) != 0)
				run_command(CMD_WRITE, BYTE_W'($urandom), 1'($urandom), pick_ack_after());
			else
				run_command(CMD_READ, BYTE_W'($urandom), 1'($urandom), 0);
		end
		run_command(CMD_STOP, BYTE_W'($urandom), 1'($urandom), 0);
	endtask

	task automatic random_phase(input logic [TICKS_W-1:0] ticks,
			input logic [TIMEOUT_W-1:0] timeout, input int unsigned n_active);
		int unsigned stop_at;
		int unsigned pause_at;
		bit          paused;
		settle();
		write_regs(ticks, timeout);
		stop_at  = sb.n_active + n_active;
		pause_at = sb.n_active + n_active / 2;
		paused   = 1'b0;
		while (sb.n_active < stop_at) begin
			// switch idling on and off now and then
			if ($urandom_range(0, 7) == 0) begin
				tx_idle = $urandom_range(0, 1);
				rx_idle = $urandom_range(0, 1);
			end
			if ($urandom_range(0, 99) < 75)
				run_transfer();
			else
				run_command(CMD_W'($urandom), BYTE_W'($urandom), 1'($urandom),
						pick_ack_after());
			repeat ($urandom_range(0, 2))
				send_tick(CMD_NONE, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
			if (!paused && sb.n_active >= pause_at) begin
				settle();
				paused = 1'b1;
			end
		end
	endtask

	// Result side: stall at random, then take and check one transaction
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.check_pins(m_tdata);
		end
	end

	initial begin
		int unsigned w;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: 5 ticks per phase, timeout 250
		run_command(CMD_START, 8'h00, 1'b0, 0);
		run_command(CMD_WRITE, 8'hA5, 1'b0, 3);
		run_command(CMD_READ, 8'h00, 1'b1, 0);
		run_command(CMD_STOP, 8'h00, 1'b0, 0);

		// zero phase ticks acts as one; zero timeout fails on the first high sample
		settle();
		write_regs('0, '0);
		run_command(CMD_WRITE, 8'hFF, 1'b0, -1);
		run_command(CMD_WRITE, 8'h00, 1'b1, 0);
		run_command(CMD_READ, 8'hFF, 1'b0, 0);
		run_command(CMD_READ, 8'h00, 1'b1, 0);
		run_command(CMD_W'(int'(CMD_READ) + 1), 8'hFF, 1'b1, 0);
		run_command(CMD_W'(int'(CMD_READ) + 2), 8'h00, 1'b0, 0);
		run_command(CMD_W'(CMD_CODES - 1), 8'hFF, 1'b1, 0);
		run_command(CMD_NONE, 8'h00, 1'b0, 0);

		// longest timeout: ack on the last allowed sample, then no ack at all
		settle();
		write_regs(TICKS_W'(1), '1);
		run_command(CMD_START, 8'h00, 1'b0, 0);
		run_command(CMD_WRITE, 8'h80, 1'b0, 255);
		run_command(CMD_WRITE, 8'h01, 1'b0, -1);
		run_command(CMD_READ, 8'h00, 1'b0, 0);
		run_command(CMD_STOP, 8'h00, 1'b0, 0);

		// a long phase hold, on the shortest command, at full rate
		settle();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_regs(TICKS_W'(20), TIMEOUT_W'(1));
		run_command(CMD_STOP, 8'h00, 1'b0, 0);
		settle();
		tx_idle = 1'b1;
		rx_idle = 1'b1;

		random_phase(TICKS_W'(1), TIMEOUT_W'($urandom_range(0, 3)), PHASE_ACTIVE);
		random_phase('0, TIMEOUT_W'($urandom_range(1, 6)), PHASE_ACTIVE);
		random_phase(TICKS_W'($urandom_range(2, 3)), '0, PHASE_ACTIVE);
		random_phase(TICKS_W'(1), TIMEOUT_W'($urandom_range(9, 16)), PHASE_ACTIVE);
		random_phase(TICKS_W'($urandom_range(0, 2)), TIMEOUT_W'($urandom_range(0, 8)),
				PHASE_ACTIVE);

		// drain the outstanding results, then a short tail
		s_tvalid <= 1'b0;
		for (w = 0; w < DRAIN_LIMIT && sb.pending() != 0; w++) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.n_errors++;
		end

		$display("Ran %0d ticks (%0d inside sequences): %0d start, %0d stop, %0d write, %0d read",
				sb.n_ticks, sb.n_active, sb.n_cmd[CMD_START], sb.n_cmd[CMD_STOP],
				sb.n_cmd[CMD_WRITE], sb.n_cmd[CMD_READ]);
		$display("Writes acked %0d, not acked %0d; %0d results checked, %0d mismatches",
				sb.n_acks, sb.n_nacks, sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("tb_i2c_master_byte_sequencer passed");
		end else begin
			$display("tb_i2c_master_byte_sequencer failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("tb_i2c_master_byte_sequencer failed");
		$finish;
	end

endmodule

FILE: i2c_master_byte_sequencer.f
hw/rtl/i2cms_pkg.sv
hw/rtl/i2c_master_byte_sequencer.sv
dv/tb_i2c_master_byte_sequencer.sv
